### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TFQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timed_frame_queue: same-cycle check failed");

// Next-cycle implication.
`define TFQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timed_frame_queue: next-cycle check failed");

`endif

### hw/rtl/tfq_pkg.sv
// ---------------------------------------------------------------------------
// tfq_pkg
// Types and constants of the timed frame queue.
// ---------------------------------------------------------------------------
package tfq_pkg;

	localparam int unsigned TFQ_CAPACITY    = 32;
	localparam int unsigned TFQ_HANDLE_BITS = 32;
	localparam int unsigned PTS_W           = 64;
	localparam int unsigned HANDLE_PORT_W   = 32;
	localparam int unsigned COUNT_PORT_W    = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DROP,
		ST_PUSH,
		ST_ANCHOR,
		ST_DIFF,
		ST_TARGET,
		ST_POP,
		ST_DONE
	} tfq_state_t;

	typedef enum logic [1:0] {
		ALU_DIFF,
		ALU_TARGET,
		ALU_CMP
	} tfq_alu_op_t;

	typedef struct packed {
		logic        rd_next;
		tfq_alu_op_t alu_op;
		logic        mem_we;
		logic        load_result;
	} tfq_ctrl_t;

endpackage

### hw/rtl/timed_frame_queue.sv
// ---------------------------------------------------------------------------
// timed_frame_queue
// Ring of timestamped frame handles, drop-oldest on overflow, popped by ticks.
// ---------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  --------  -------------------------  -----------------------------------------
//  item      item_valid / item_stall    cmd, frame_handle, frame_pts, now_time
//  result    result_valid / result_stall shown_valid, shown_handle, shown_pts,
//                                       taken_count, depth, dropped, dropped_handle
//
// A push writes its entry at the tail, first dropping the oldest entry when the ring is
// full; a zero handle leaves the ring alone. A tick anchors media and wall zero if the
// ring is not yet anchored and holds an entry, forms the difference and the target, then
// pops due entries until one is not yet due or the ring is empty. One 65-bit add/compare
// unit serves all timestamp arithmetic; a tick pops one entry per cycle. Reset clears
// pointers, anchor and shown frame. item_stall is high while an item is in work; a
// stalled result holds in its register and the next item is accepted meanwhile.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_frame_queue import tfq_pkg::*; #(
	parameter int unsigned CAPACITY    = TFQ_CAPACITY,
	parameter int unsigned HANDLE_BITS = TFQ_HANDLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            cmd,
	input  logic        [HANDLE_PORT_W-1:0] frame_handle,
	input  logic signed [PTS_W-1:0]         frame_pts,
	input  logic signed [PTS_W-1:0]         now_time,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            shown_valid,
	output logic        [HANDLE_PORT_W-1:0] shown_handle,
	output logic signed [PTS_W-1:0]         shown_pts,
	output logic        [COUNT_PORT_W-1:0]  taken_count,
	output logic        [COUNT_PORT_W-1:0]  depth,
	output logic                            dropped,
	output logic        [HANDLE_PORT_W-1:0] dropped_handle
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned HW = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;

	// sequencer and ring control
	tfq_state_t      state_q, state_d;
	tfq_ctrl_t       ctrl;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic            anchored_q;
	logic [PTS_W-1:0] media_zero_q;
	logic [PTS_W-1:0] wall_zero_q;
	logic [HW-1:0]   cur_handle_q;
	logic [PTS_W-1:0] cur_pts_q;
	logic            result_valid_q;

	// captured item and working values
	logic            cmd_q;
	logic [HW-1:0]   in_handle_q;
	logic [PTS_W-1:0] in_pts_q;
	logic [PTS_W-1:0] in_now_q;
	logic [PTS_W-1:0] target_q;
	logic [CW-1:0]   taken_q;
	logic            dropped_q;
	logic [HW-1:0]   drop_handle_q;

	// ring storage
	logic [HW-1:0]    handle_mem_q [CAPACITY];
	logic [PTS_W-1:0] pts_mem_q    [CAPACITY];
	logic [HW-1:0]    rd_handle_q;
	logic [PTS_W-1:0] rd_pts_q;

	// result register
	logic                     res_shown_valid_q;
	logic [HANDLE_PORT_W-1:0] res_handle_q;
	logic [PTS_W-1:0]         res_pts_q;
	logic [COUNT_PORT_W-1:0]  res_taken_q;
	logic [COUNT_PORT_W-1:0]  res_depth_q;
	logic                     res_dropped_q;
	logic [HANDLE_PORT_W-1:0] res_drop_handle_q;

	logic             accept;
	logic             result_free;
	logic [HW-1:0]    in_handle;
	logic [AW-1:0]    head_next;
	logic [CW:0]      tail_sum;
	logic [CW:0]      tail_wrap;
	logic [AW-1:0]    tail_idx;
	logic [AW-1:0]    rd_addr;
	logic [PTS_W-1:0] alu_a;
	logic [PTS_W-1:0] alu_b;
	logic             alu_sub;
	logic [PTS_W:0]   alu_b_ext;
	logic [PTS_W:0]   alu_sum;
	logic             pts_le;

	assign item_stall  = (state_q != ST_IDLE);
	assign accept      = item_valid && !item_stall;
	assign result_free = !result_valid_q || !result_stall;
	assign in_handle   = frame_handle[HW-1:0];

	// Advance the ring index with wrap at the capacity.
	assign head_next = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

	// Tail slot: head plus fill, folded once back into the ring.
	assign tail_sum  = (CW + 1)'(head_q) + (CW + 1)'(count_q);
	assign tail_wrap = (tail_sum >= (CW + 1)'(CAPACITY)) ? tail_sum - (CW + 1)'(CAPACITY)
	                                                     : tail_sum;
	assign tail_idx  = tail_wrap[AW-1:0];

	// Shared add/compare unit. Sign-extend to 65 bits so the compare is exact;
	// the low 64 bits give the wrapping difference and target.
	always_comb begin
		case (ctrl.alu_op)
			ALU_DIFF: begin
				alu_a   = in_now_q;
				alu_b   = wall_zero_q;
				alu_sub = 1'b1;
			end
			ALU_TARGET: begin
				alu_a   = media_zero_q;
				alu_b   = target_q;
				alu_sub = 1'b0;
			end
			default: begin
				alu_a   = target_q;
				alu_b   = rd_pts_q;
				alu_sub = 1'b1;
			end
		endcase
	end

	assign alu_b_ext = {alu_b[PTS_W-1], alu_b};
	assign alu_sum   = {alu_a[PTS_W-1], alu_a} + (alu_sub ? ~alu_b_ext : alu_b_ext)
	                 + (PTS_W + 1)'(alu_sub);
	// target - pts is not negative: the head entry is due
	assign pts_le    = !alu_sum[PTS_W];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!cmd) begin
						if (in_handle == '0)
							state_d = ST_DONE;
						else if (count_q == CW'(CAPACITY))
							state_d = ST_DROP;
						else
							state_d = ST_PUSH;
					end else begin
						if (anchored_q)
							state_d = ST_DIFF;
						else if (count_q != '0)
							state_d = ST_ANCHOR;
						else
							state_d = ST_DONE;
					end
				end
			end
			ST_DROP:   state_d = ST_PUSH;
			ST_PUSH:   state_d = ST_DONE;
			ST_ANCHOR: state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_TARGET;
			ST_TARGET: state_d = (count_q != '0) ? ST_POP : ST_DONE;
			ST_POP: begin
				if (!pts_le || count_q == CW'(1))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (result_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs. The ring read address defaults to the head, so the
	// head entry is already registered when a drop, anchor or pop needs it.
	always_comb begin
		ctrl = '{rd_next: 1'b0, alu_op: ALU_CMP, mem_we: 1'b0, load_result: 1'b0};
		unique case (state_q)
			ST_IDLE, ST_DROP, ST_ANCHOR: ;
			ST_PUSH:   ctrl.mem_we = 1'b1;
			ST_DIFF:   ctrl.alu_op = ALU_DIFF;
			ST_TARGET: ctrl.alu_op = ALU_TARGET;
			ST_POP: begin
				ctrl.alu_op  = ALU_CMP;
				// prefetch the following entry while this one is taken
				ctrl.rd_next = pts_le;
			end
			ST_DONE:   ctrl.load_result = result_free;
			default: ;
		endcase
	end

	assign rd_addr = ctrl.rd_next ? head_next : head_q;

	// Ring storage: one write port, one registered read port.
	always_ff @(posedge clk) begin
		rd_handle_q <= handle_mem_q[rd_addr];
		rd_pts_q    <= pts_mem_q[rd_addr];
		if (ctrl.mem_we) begin
			handle_mem_q[tail_idx] <= in_handle_q;
			pts_mem_q[tail_idx]    <= in_pts_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			head_q         <= '0;
			count_q        <= '0;
			anchored_q     <= 1'b0;
			media_zero_q   <= '0;
			wall_zero_q    <= '0;
			cur_handle_q   <= '0;
			cur_pts_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_DROP: begin
					// drop the oldest entry to make room
					head_q  <= head_next;
					count_q <= CW'(CAPACITY - 1);
				end
				ST_PUSH: count_q <= count_q + 1'b1;
				ST_ANCHOR: begin
					media_zero_q <= rd_pts_q;
					wall_zero_q  <= in_now_q;
					anchored_q   <= 1'b1;
				end
				ST_POP: begin
					if (pts_le) begin
						cur_handle_q <= rd_handle_q;
						cur_pts_q    <= rd_pts_q;
						head_q       <= head_next;
						count_q      <= count_q - 1'b1;
					end
				end
				ST_IDLE, ST_DIFF, ST_TARGET, ST_DONE: ;
				default: ;
			endcase
			if (ctrl.load_result)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	// Item capture and working values.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q         <= cmd;
			in_handle_q   <= in_handle;
			in_pts_q      <= frame_pts;
			in_now_q      <= now_time;
			taken_q       <= '0;
			dropped_q     <= 1'b0;
			drop_handle_q <= '0;
		end
		if (state_q == ST_DROP) begin
			dropped_q     <= 1'b1;
			drop_handle_q <= rd_handle_q;
		end
		if (state_q == ST_DIFF || state_q == ST_TARGET)
			target_q <= alu_sum[PTS_W-1:0];
		if (state_q == ST_POP && pts_le)
			taken_q <= taken_q + 1'b1;
	end

	// Result register: hold until taken.
	always_ff @(posedge clk) begin
		if (ctrl.load_result) begin
			res_shown_valid_q <= (cur_handle_q != '0);
			res_handle_q      <= HANDLE_PORT_W'(cur_handle_q);
			res_pts_q         <= cur_pts_q;
			res_taken_q       <= cmd_q ? COUNT_PORT_W'(taken_q) : '0;
			res_depth_q       <= COUNT_PORT_W'(count_q);
			res_dropped_q     <= dropped_q;
			res_drop_handle_q <= HANDLE_PORT_W'(drop_handle_q);
		end
	end

	assign result_valid   = result_valid_q;
	assign shown_valid    = res_shown_valid_q;
	assign shown_handle   = res_handle_q;
	assign shown_pts      = res_pts_q;
	assign taken_count    = res_taken_q;
	assign depth          = res_depth_q;
	assign dropped        = res_dropped_q;
	assign dropped_handle = res_drop_handle_q;

	// A pop only runs on an anchored ring that still holds an entry.
	`TFQ_ASSERT_NOW(a_pop_has_entry, state_q == ST_POP, anchored_q && count_q != '0)
	// A drop only happens on a full ring.
	`TFQ_ASSERT_NOW(a_drop_when_full, state_q == ST_DROP, count_q == CW'(CAPACITY))
	// Entries taken plus entries left never exceed the ring size.
	`TFQ_ASSERT_NOW(a_taken_bound, state_q == ST_POP,
		((CW + 1)'(taken_q) + (CW + 1)'(count_q)) <= (CW + 1)'(CAPACITY))
	// A completed tick never reports a pushed entry as dropped.
	`TFQ_ASSERT_NEXT(a_tick_no_drop, state_q == ST_DONE && ctrl.load_result && cmd_q,
		!res_dropped_q)

endmodule

### sim/tb_timed_frame_queue.sv
// ---------------------------------------------------------------------------
// tb_timed_frame_queue
// Self-checking bench for the timed frame queue: a directed table of pushes
// and ticks (anchoring, wrap of the target, drop-oldest, full pops), then
// randomized push/tick traffic with random idling on both channels and one
// long receiver hold-off. Every result is checked field by field against the
// table's expected report or a cycle-free playout predictor kept inside the bench.
// ---------------------------------------------------------------------------
module tb_timed_frame_queue import tfq_pkg::*;;

	localparam bit CMD_PUSH = 1'b0;
	localparam bit CMD_TICK = 1'b1;

	localparam int unsigned RING         = TFQ_CAPACITY;
	localparam int unsigned RANDOM_ITEMS = 1370;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned HOLD_CYCLES  = 400;

	localparam logic [PTS_W-1:0] PTS_MIN = 64'h8000_0000_0000_0000;
	localparam logic [PTS_W-1:0] PTS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// One result item as the block reports it.
	typedef struct packed {
		logic                     shown_v;
		logic [HANDLE_PORT_W-1:0] handle;
		logic [PTS_W-1:0]         pts;
		logic [COUNT_PORT_W-1:0]  taken;
		logic [COUNT_PORT_W-1:0]  fill;
		logic                     drop;
		logic [HANDLE_PORT_W-1:0] drop_handle;
	} frame_report_t;

	// One row of the directed script; pushes repeat with stepping handle and pts.
	typedef struct {
		bit                       op;
		bit [HANDLE_PORT_W-1:0]   handle;
		bit [PTS_W-1:0]           pts;
		bit [PTS_W-1:0]           now;
		int unsigned              reps;
		bit [PTS_W-1:0]           pts_step;
		bit                       known;
		frame_report_t            want;
	} script_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            item_valid;
	logic                            item_stall;
	logic                            cmd;
	logic        [HANDLE_PORT_W-1:0] frame_handle;
	logic signed [PTS_W-1:0]         frame_pts;
	logic signed [PTS_W-1:0]         now_time;
	logic                            result_valid;
	logic                            result_stall;
	logic                            shown_valid;
	logic        [HANDLE_PORT_W-1:0] shown_handle;
	logic signed [PTS_W-1:0]         shown_pts;
	logic        [COUNT_PORT_W-1:0]  taken_count;
	logic        [COUNT_PORT_W-1:0]  depth;
	logic                            dropped;
	logic        [HANDLE_PORT_W-1:0] dropped_handle;

	// Playout predictor state: the ring, the anchor and the frame on screen.
	bit [HANDLE_PORT_W-1:0] ring_handle [RING];
	bit [PTS_W-1:0]         ring_pts    [RING];
	int unsigned            ring_head;
	int unsigned            ring_fill;
	bit                     clock_locked;
	bit [PTS_W-1:0]         media_origin;
	bit [PTS_W-1:0]         wall_origin;
	bit [HANDLE_PORT_W-1:0] on_screen_handle;
	bit [PTS_W-1:0]         on_screen_pts;

	frame_report_t pending_reports [$];
	script_row_t   script [$];
	int unsigned   mismatches;
	bit            tx_calm;
	logic          rx_freeze;
	event          hold_off_go;

	timed_frame_queue dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#2_000_000;
		$display("ERROR: timeout, %0d results still expected", pending_reports.size());
		$display("Mismatches found");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		if (mismatches < 40)
			$display("ERROR at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Advance the predictor by one item and return the report it should produce.
	function automatic frame_report_t advance_playout(input bit op,
			input bit [HANDLE_PORT_W-1:0] h, input bit [PTS_W-1:0] pts,
			input bit [PTS_W-1:0] now);
		frame_report_t r;
		bit [PTS_W-1:0] target;
		int unsigned tail;
		int unsigned popped;
		popped        = 0;
		r.drop        = 1'b0;
		r.drop_handle = '0;
		if (op == CMD_PUSH) begin
			// A zero handle is no frame: leave the ring alone.
			if (h != 0) begin
				if (ring_fill >= RING) begin
					r.drop        = 1'b1;
					r.drop_handle = ring_handle[ring_head];
					ring_head     = (ring_head + 1) % RING;
					ring_fill--;
				end
				tail              = (ring_head + ring_fill) % RING;
				ring_handle[tail] = h;
				ring_pts[tail]    = pts;
				ring_fill++;
			end
		end else begin
			// Lock media and wall zero on the first tick that sees a frame.
			if (!clock_locked && ring_fill > 0) begin
				media_origin = ring_pts[ring_head];
				wall_origin  = now;
				clock_locked = 1'b1;
			end
			if (clock_locked) begin
				// Wraps modulo 2^64; the compare below is signed.
				target = media_origin + (now - wall_origin);
				while (ring_fill > 0 && $signed(ring_pts[ring_head]) <= $signed(target)) begin
					on_screen_handle = ring_handle[ring_head];
					on_screen_pts    = ring_pts[ring_head];
					ring_head        = (ring_head + 1) % RING;
					ring_fill--;
					popped++;
				end
			end
		end
		r.shown_v = on_screen_handle != 0;
		r.handle  = on_screen_handle;
		r.pts     = on_screen_pts;
		r.taken   = popped[COUNT_PORT_W-1:0];
		r.fill    = ring_fill[COUNT_PORT_W-1:0];
		return r;
	endfunction

	task automatic plan_stim(input bit op, input bit [HANDLE_PORT_W-1:0] h,
			input bit [PTS_W-1:0] pts, input bit [PTS_W-1:0] now,
			input int unsigned reps, input bit [PTS_W-1:0] pts_step);
		script.push_back('{op, h, pts, now, reps, pts_step, 1'b0, '0});
	endtask

	task automatic plan_known(input bit op, input bit [HANDLE_PORT_W-1:0] h,
			input bit [PTS_W-1:0] pts, input bit [PTS_W-1:0] now, input frame_report_t want);
		script.push_back('{op, h, pts, now, 1, '0, 1'b1, want});
	endtask

	// Offer one item after a random gap, hold it until accepted, then log the
	// expected report. Fields the operation ignores carry random bits.
	task automatic offer_item(input bit op, input bit [HANDLE_PORT_W-1:0] h,
			input bit [PTS_W-1:0] pts, input bit [PTS_W-1:0] now,
			input bit known, input frame_report_t want);
		int unsigned gap;
		frame_report_t predicted;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		cmd          <= op;
		frame_handle <= (op == CMD_PUSH) ? h : $urandom;
		frame_pts    <= (op == CMD_PUSH) ? pts : {$urandom, $urandom};
		now_time     <= (op == CMD_TICK) ? now : {$urandom, $urandom};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted = advance_playout(op, h, pts, now);
		pending_reports.push_back(known ? want : predicted);
	endtask

	// Directed script, then random traffic, then drain.
	initial begin : frame_source
		int unsigned    roll;
		int unsigned    push_share;
		int unsigned    lag_span;
		bit             op;
		bit [HANDLE_PORT_W-1:0] h;
		bit [PTS_W-1:0] pts;
		bit [PTS_W-1:0] now;
		bit [PTS_W-1:0] media_clock;
		bit [PTS_W-1:0] target;

		item_valid   <= 1'b0;
		cmd          <= CMD_PUSH;
		frame_handle <= '0;
		frame_pts    <= '0;
		now_time     <= '0;
		mismatches   = 0;
		tx_calm      = 1'b0;
		ring_head    = 0;
		ring_fill    = 0;
		clock_locked = 1'b0;
		media_origin = '0;
		wall_origin  = '0;
		on_screen_handle = '0;
		on_screen_pts    = '0;

		// Tick on an empty ring before any anchor: nothing shown, nothing taken.
		plan_known(CMD_TICK, 32'd0, 64'd0, 64'd0, '{1'b0, 32'd0, 64'd0, 6'd0, 6'd0, 1'b0, 32'd0});
		// Zero handle push is ignored.
		plan_known(CMD_PUSH, 32'd0, 64'd5, 64'd0, '{1'b0, 32'd0, 64'd0, 6'd0, 6'd0, 1'b0, 32'd0});
		// Extremes of handle and timestamp.
		plan_known(CMD_PUSH, 32'hFFFF_FFFF, PTS_MIN, 64'd0,
			'{1'b0, 32'd0, 64'd0, 6'd0, 6'd1, 1'b0, 32'd0});
		plan_known(CMD_PUSH, 32'd1, PTS_MAX, 64'd0,
			'{1'b0, 32'd0, 64'd0, 6'd0, 6'd2, 1'b0, 32'd0});
		// Anchor at wall 0 on the oldest pts; target equals it, so take one.
		plan_known(CMD_TICK, 32'd0, 64'd0, 64'd0,
			'{1'b1, 32'hFFFF_FFFF, PTS_MIN, 6'd1, 6'd1, 1'b0, 32'd0});
		// Wall step of -1 wraps the target to the largest pts.
		plan_known(CMD_TICK, 32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			'{1'b1, 32'd1, PTS_MAX, 6'd1, 6'd0, 1'b0, 32'd0});
		// Anchored tick on an empty ring keeps the shown frame.
		plan_known(CMD_TICK, 32'd0, 64'd0, 64'd5,
			'{1'b1, 32'd1, PTS_MAX, 6'd0, 6'd0, 1'b0, 32'd0});
		// Overfill by one: the last push drops the oldest entry.
		plan_stim(CMD_PUSH, 32'h0000_1000, 64'd0, 64'd0, RING + 1, 64'd100);
		// Zero handle on a full ring still changes nothing.
		plan_known(CMD_PUSH, 32'd0, 64'd7, 64'd0,
			'{1'b1, 32'd1, PTS_MAX, 6'd0, 6'd32, 1'b0, 32'd0});
		// Partial pop, the same target again, a negative target, then the rest.
		plan_stim(CMD_TICK, 32'd0, 64'd0, PTS_MIN + 64'd1550, 1, 64'd0);
		plan_stim(CMD_TICK, 32'd0, 64'd0, PTS_MIN + 64'd1550, 1, 64'd0);
		plan_stim(CMD_TICK, 32'd0, 64'd0, PTS_MAX, 1, 64'd0);
		plan_stim(CMD_TICK, 32'd0, 64'd0, PTS_MIN + 64'd1_000_000, 1, 64'd0);
		// Negative timestamps, equal pts on two frames.
		plan_stim(CMD_PUSH, 32'h8000_0000, -64'sd5, 64'd0, 1, 64'd0);
		plan_stim(CMD_PUSH, 32'h7FFF_FFFF, -64'sd5, 64'd0, 1, 64'd0);
		plan_stim(CMD_TICK, 32'd0, 64'd0, PTS_MIN, 1, 64'd0);
		// Full ring of equal pts plus one drop, then one tick takes all of it.
		plan_stim(CMD_PUSH, 32'hA5A5_0000, 64'd42, 64'd0, RING, 64'd0);
		plan_stim(CMD_PUSH, 32'h5A5A_5A5A, 64'd43, 64'd0, 1, 64'd0);
		plan_stim(CMD_TICK, 32'd0, 64'd0, PTS_MIN + 64'd43, 1, 64'd0);
		plan_stim(CMD_TICK, 32'd0, 64'd0, 64'd0, 1, 64'd0);

		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (script[r])
			for (int unsigned i = 0; i < script[r].reps; i++)
				offer_item(script[r].op, script[r].handle + i,
					script[r].pts + i * script[r].pts_step, script[r].now,
					script[r].known, script[r].want);

		// Random traffic: frames pushed on a rising media clock with some jitter,
		// ticks aimed at a target trailing the newest frame, a little noise.
		media_clock = 64'd10_000_000;
		push_share  = 60;
		lag_span    = 8000;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: push_share = 35;
					1: push_share = 60;
					default: push_share = 85;
				endcase
				case ($urandom_range(0, 2))
					0: lag_span = 1500;
					1: lag_span = 8000;
					default: lag_span = 40000;
				endcase
			end
			if (k % 64 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			// Keep offering back to back while the receiver holds off.
			if (k == 300) begin
				tx_calm = 1'b1;
				-> hold_off_go;
			end
			roll = $urandom_range(0, 99);
			h    = '0;
			pts  = '0;
			now  = '0;
			if (roll < 6) begin
				op  = $urandom_range(0, 1);
				h   = $urandom;
				pts = {$urandom, $urandom};
				now = {$urandom, $urandom};
			end else if (roll < 6 + push_share) begin
				op          = CMD_PUSH;
				h           = ($urandom_range(0, 24) == 0) ? 32'd0 : $urandom;
				media_clock = media_clock + $urandom_range(1, 800);
				pts         = media_clock - $urandom_range(0, 300);
			end else begin
				op     = CMD_TICK;
				target = media_clock - $urandom_range(0, lag_span);
				now    = target - media_origin + wall_origin;
			end
			offer_item(op, h, pts, now, 1'b0, '0);
		end
		item_valid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Assert reset at the start, then release it for good.
	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// One long receiver hold-off so the result register fills and the input stalls.
	initial begin : long_hold
		rx_freeze <= 1'b0;
		@(hold_off_go);
		rx_freeze <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_freeze <= 1'b0;
	end

	// Result side: check every accepted report, then stall for a random count.
	initial begin : report_sink
		int unsigned   hold;
		int unsigned   seen;
		bit            rx_calm;
		frame_report_t want;
		result_stall <= 1'b0;
		hold    = 0;
		seen    = 0;
		rx_calm = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
				if (pending_reports.size() == 0) begin
					flag_mismatch($sformatf("report %0d arrived with nothing expected", seen));
				end else begin
					want = pending_reports.pop_front();
					if (shown_valid !== want.shown_v)
						flag_mismatch($sformatf("report %0d shown_valid %b, expected %b",
							seen, shown_valid, want.shown_v));
					if (shown_handle !== want.handle)
						flag_mismatch($sformatf("report %0d shown_handle %h, expected %h",
							seen, shown_handle, want.handle));
					if (shown_pts !== want.pts)
						flag_mismatch($sformatf("report %0d shown_pts %h, expected %h",
							seen, shown_pts, want.pts));
					if (taken_count !== want.taken)
						flag_mismatch($sformatf("report %0d taken_count %0d, expected %0d",
							seen, taken_count, want.taken));
					if (depth !== want.fill)
						flag_mismatch($sformatf("report %0d depth %0d, expected %0d",
							seen, depth, want.fill));
					if (dropped !== want.drop)
						flag_mismatch($sformatf("report %0d dropped %b, expected %b",
							seen, dropped, want.drop));
					if (dropped_handle !== want.drop_handle)
						flag_mismatch($sformatf("report %0d dropped_handle %h, expected %h",
							seen, dropped_handle, want.drop_handle));
				end
				seen++;
				// Alternate stretches with no stalls and stretches with random stalls.
				if (seen % 80 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				hold = rx_calm ? 0 : $urandom_range(0, 16);
			end else if (hold != 0) begin
				hold--;
			end
			result_stall <= (rx_freeze === 1'b1) || (hold != 0);
		end
	end

endmodule
